// File: src/pngdf_pkg.sv
package pngdf_pkg;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    CK_UNKNOWN,
    CK_IHDR,
    CK_PLTE,
    CK_IDAT,
    CK_IEND
  } chunk_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_HEADER,
    KIND_END,
    KIND_ERROR
  } kind_t;

  localparam logic [2:0] ERR_SIGNATURE   = 3'd0;
  localparam logic [2:0] ERR_DEPTH       = 3'd1;
  localparam logic [2:0] ERR_COLOR_TYPE  = 3'd2;
  localparam logic [2:0] ERR_COMPRESSION = 3'd3;
  localparam logic [2:0] ERR_FILTER      = 3'd4;
  localparam logic [2:0] ERR_INTERLACE   = 3'd5;
  localparam logic [2:0] ERR_PALETTE     = 3'd6;

  localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
  localparam logic [31:0] TAG_PLTE = 32'h504C_5445;
  localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
  localparam logic [31:0] TAG_IEND = 32'h4945_4E44;

  localparam logic [7:0] HDR_DEPTH      = 8'd8;
  localparam logic [7:0] HDR_COLOR_RGBA = 8'd6;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'd137;
      3'd1: b = 8'd80;
      3'd2: b = 8'd78;
      3'd3: b = 8'd71;
      3'd4: b = 8'd13;
      3'd5: b = 8'd10;
      3'd6: b = 8'd26;
      3'd7: b = 8'd10;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// File: src/pngdf_if.sv
interface pngdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface pngdf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output payload_byte, output image_width,
                  output image_height, output error_code, input ready);
  modport sink (input valid, input kind, input payload_byte, input image_width,
                input image_height, input error_code, output ready);
endinterface

// File: src/png_chunk_deframer_core.sv
// Channel   Modport  Payload
// stream    sink     data_byte, file_start
// results   source   kind, payload_byte, image_width, image_height, error_code
//
// One byte is taken per cycle while stream.ready is high; a byte's result, if
// it has one, appears on the next cycle from the output register.
// The whole parse step is one pass of logic between the state registers and
// the output register, so a new byte can follow in every cycle.
// Reset is synchronous and puts the parser in the signature phase.
// A stalled result holds the output register, and stream takes a transfer only
// while that register is empty or is being drained in the same cycle.
module png_chunk_deframer_core
  import pngdf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pngdf_in_if.sink      stream,
  pngdf_out_if.source   results
);

  phase_t      phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] chunk_length, chunk_length_next;
  chunk_t      chunk_kind, chunk_kind_next;
  logic [31:0] gather_word, gather_word_next;
  logic [31:0] width_store, width_store_next;
  logic [31:0] height_store, height_store_next;

  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_payload;
  logic [31:0] out_width;
  logic [31:0] out_height;
  logic [2:0]  out_error;

  logic        accept;
  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_payload;
  logic [31:0] res_width;
  logic [31:0] res_height;
  logic [2:0]  res_error;

  assign stream.ready = !out_valid || results.ready;
  assign accept       = stream.valid && stream.ready;

  always_comb begin
    phase_t      ph;
    logic [31:0] bc;
    logic [31:0] clen;
    chunk_t      ck;
    logic [31:0] gw;
    logic [31:0] ws;
    logic [31:0] hs;
    logic [31:0] word;
    logic [31:0] bc_inc;
    logic [7:0]  b;
    logic        bad;
    logic [2:0]  bad_code;
    logic        last;

    b = stream.data_byte;
    if (stream.file_start) begin
      ph   = PH_SIG;
      bc   = '0;
      clen = '0;
      ck   = CK_UNKNOWN;
      gw   = '0;
      ws   = '0;
      hs   = '0;
    end else begin
      ph   = phase;
      bc   = byte_count;
      clen = chunk_length;
      ck   = chunk_kind;
      gw   = gather_word;
      ws   = width_store;
      hs   = height_store;
    end

    word     = {gw[23:0], b};
    bc_inc   = bc + 32'd1;
    bad      = 1'b0;
    bad_code = ERR_SIGNATURE;
    last     = (bc_inc == clen);

    phase_next        = ph;
    byte_count_next   = bc;
    chunk_length_next = clen;
    chunk_kind_next   = ck;
    gather_word_next  = gw;
    width_store_next  = ws;
    height_store_next = hs;

    res_valid   = 1'b0;
    res_kind    = KIND_PAYLOAD;
    res_payload = '0;
    res_width   = '0;
    res_height  = '0;
    res_error   = '0;

    unique case (ph)
      PH_SIG: begin
        if (b != sig_byte(bc[2:0])) begin
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_error  = ERR_SIGNATURE;
          phase_next = PH_DONE;
        end else if (bc == 32'd7) begin
          phase_next       = PH_LEN;
          byte_count_next  = '0;
          gather_word_next = '0;
        end else begin
          byte_count_next = bc_inc;
        end
      end
      PH_LEN: begin
        if (bc == 32'd3) begin
          chunk_length_next = word;
          phase_next        = PH_TYPE;
          byte_count_next   = '0;
          gather_word_next  = '0;
        end else begin
          gather_word_next = word;
          byte_count_next  = bc_inc;
        end
      end
      PH_TYPE: begin
        if (bc != 32'd3) begin
          gather_word_next = word;
          byte_count_next  = bc_inc;
        end else begin
          byte_count_next  = '0;
          gather_word_next = '0;
          priority if (word == TAG_IHDR) chunk_kind_next = CK_IHDR;
          else if (word == TAG_PLTE) chunk_kind_next = CK_PLTE;
          else if (word == TAG_IDAT) chunk_kind_next = CK_IDAT;
          else if (word == TAG_IEND) chunk_kind_next = CK_IEND;
          else chunk_kind_next = CK_UNKNOWN;

          if (word == TAG_PLTE) begin
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_error  = ERR_PALETTE;
            phase_next = PH_DONE;
          end else if (word == TAG_IEND) begin
            res_valid  = 1'b1;
            res_kind   = KIND_END;
            phase_next = PH_DONE;
          end else begin
            if (word == TAG_IHDR) begin
              width_store_next  = '0;
              height_store_next = '0;
            end
            if (clen == 32'd0) begin
              phase_next = PH_CRC;
              if (word == TAG_IHDR) begin
                res_valid  = 1'b1;
                res_kind   = KIND_ERROR;
                res_error  = ERR_DEPTH;
                phase_next = PH_DONE;
              end
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        if (ck == CK_IDAT) begin
          res_valid   = 1'b1;
          res_kind    = KIND_PAYLOAD;
          res_payload = b;
        end else if (ck == CK_IHDR) begin
          priority if (bc < 32'd4) begin
            width_store_next = {ws[23:0], b};
          end else if (bc < 32'd8) begin
            height_store_next = {hs[23:0], b};
          end else if (bc == 32'd8) begin
            bad      = (b != HDR_DEPTH);
            bad_code = ERR_DEPTH;
          end else if (bc == 32'd9) begin
            bad      = (b != HDR_COLOR_RGBA);
            bad_code = ERR_COLOR_TYPE;
          end else if (bc == 32'd10) begin
            bad      = (b != 8'd0);
            bad_code = ERR_COMPRESSION;
          end else if (bc == 32'd11) begin
            bad      = (b != 8'd0);
            bad_code = ERR_FILTER;
          end else if (bc == 32'd12) begin
            bad      = (b != 8'd0);
            bad_code = ERR_INTERLACE;
            if (b == 8'd0) begin
              res_valid  = 1'b1;
              res_kind   = KIND_HEADER;
              res_width  = ws;
              res_height = hs;
            end
          end else begin
            bad = 1'b0;
          end
        end

        if (bad) begin
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_error  = bad_code;
          phase_next = PH_DONE;
        end else if (last) begin
          phase_next      = PH_CRC;
          byte_count_next = '0;
          if (ck == CK_IHDR && bc < 32'd12) begin
            res_valid = 1'b1;
            if (bc < 32'd8) begin
              res_kind   = KIND_ERROR;
              res_error  = ERR_DEPTH;
              phase_next = PH_DONE;
            end else if (bc == 32'd8) begin
              res_kind   = KIND_ERROR;
              res_error  = ERR_COLOR_TYPE;
              phase_next = PH_DONE;
            end else begin
              res_kind   = KIND_HEADER;
              res_width  = ws;
              res_height = hs;
            end
          end
        end else begin
          byte_count_next = bc_inc;
        end
      end
      PH_CRC: begin
        if (bc == 32'd3) begin
          phase_next       = PH_LEN;
          byte_count_next  = '0;
          gather_word_next = '0;
        end else begin
          byte_count_next = bc_inc;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = ph;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIG;
      byte_count   <= '0;
      chunk_length <= '0;
      chunk_kind   <= CK_UNKNOWN;
      gather_word  <= '0;
      width_store  <= '0;
      height_store <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      chunk_length <= chunk_length_next;
      chunk_kind   <= chunk_kind_next;
      gather_word  <= gather_word_next;
      width_store  <= width_store_next;
      height_store <= height_store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind    <= res_kind;
      out_payload <= res_payload;
      out_width   <= res_width;
      out_height  <= res_height;
      out_error   <= res_error;
    end
  end

  assign results.valid        = out_valid;
  assign results.kind         = out_kind;
  assign results.payload_byte = out_payload;
  assign results.image_width  = out_width;
  assign results.image_height = out_height;
  assign results.error_code   = out_error;

`ifndef SYNTHESIS
  a_error_ends_parse: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && res_kind == KIND_ERROR |=> phase == PH_DONE)
    else $error("Parser did not stop after reporting an error.");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE && !(accept && stream.file_start) |=> phase == PH_DONE)
    else $error("Parser left the done phase without a new file start.");

  a_payload_from_idat: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && res_kind == KIND_PAYLOAD |->
      !stream.file_start && phase == PH_DATA && chunk_kind == CK_IDAT)
    else $error("Payload byte produced outside an image data chunk.");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid |=> results.valid)
    else $error("Result of an accepted byte was lost.");
`endif

endmodule

// File: tb/png_chunk_deframer_core_tb.sv
`timescale 1ns / 1ps

module png_chunk_deframer_core_tb;
  import pngdf_pkg::*;

  localparam int unsigned STIMULUS_BYTES = 1650;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [7:0] SIGNATURE [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};
  localparam int NO_BAD_FIELD = -1;

  typedef struct packed {
    logic       file_start;
    logic [7:0] data_byte;
  } stream_byte_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [2:0]  error_code;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst;

  pngdf_in_if  stream_ch ();
  pngdf_out_if result_ch ();

  png_chunk_deframer_core dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .results (result_ch)
  );

  always #5 clk = ~clk;

  stream_byte_t  byte_queue [$];
  parse_result_t expected_results [$];
  int unsigned   total_bytes;
  int unsigned   counted_bytes;
  int unsigned   accepted_bytes;
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   gap_left;
  int unsigned   stall_left;

  phase_t      parse_phase;
  chunk_t      chunk_type;
  logic [31:0] byte_index;
  logic [31:0] chunk_len;
  logic [31:0] shift_word;
  logic [31:0] width_seen;
  logic [31:0] height_seen;

  function automatic void reset_parser();
    parse_phase = PH_SIG;
    chunk_type  = CK_UNKNOWN;
    byte_index  = '0;
    chunk_len   = '0;
    shift_word  = '0;
    width_seen  = '0;
    height_seen = '0;
  endfunction

  function automatic bit raise_error(input logic [2:0] code, output parse_result_t r);
    parse_phase  = PH_DONE;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return 1'b1;
  endfunction

  // A header chunk that ends early is judged by the first field it never reached.
  function automatic bit header_verdict(input logic [31:0] next_field,
                                        output parse_result_t r);
    if (next_field <= 32'd8) return raise_error(ERR_DEPTH, r);
    if (next_field == 32'd9) return raise_error(ERR_COLOR_TYPE, r);
    r              = '0;
    r.kind         = KIND_HEADER;
    r.image_width  = width_seen;
    r.image_height = height_seen;
    return 1'b1;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    output parse_result_t r);
    logic [31:0] idx;
    bit          got;
    r   = '0;
    got = 1'b0;
    if (start) reset_parser();
    case (parse_phase)
      PH_SIG: begin
        if (b != SIGNATURE[byte_index[2:0]]) return raise_error(ERR_SIGNATURE, r);
        byte_index++;
        if (byte_index >= 32'd8) begin
          parse_phase = PH_LEN;
          byte_index  = '0;
          shift_word  = '0;
        end
      end
      PH_LEN: begin
        shift_word = {shift_word[23:0], b};
        byte_index++;
        if (byte_index >= 32'd4) begin
          chunk_len   = shift_word;
          parse_phase = PH_TYPE;
          byte_index  = '0;
          shift_word  = '0;
        end
      end
      PH_TYPE: begin
        shift_word = {shift_word[23:0], b};
        byte_index++;
        if (byte_index >= 32'd4) begin
          byte_index = '0;
          case (shift_word)
            TAG_IHDR: chunk_type = CK_IHDR;
            TAG_PLTE: chunk_type = CK_PLTE;
            TAG_IDAT: chunk_type = CK_IDAT;
            TAG_IEND: chunk_type = CK_IEND;
            default:  chunk_type = CK_UNKNOWN;
          endcase
          shift_word = '0;
          if (chunk_type == CK_PLTE) return raise_error(ERR_PALETTE, r);
          if (chunk_type == CK_IEND) begin
            parse_phase = PH_DONE;
            r.kind      = KIND_END;
            return 1'b1;
          end
          if (chunk_type == CK_IHDR) begin
            width_seen  = '0;
            height_seen = '0;
          end
          if (chunk_len == '0) begin
            parse_phase = PH_CRC;
            if (chunk_type == CK_IHDR) got = header_verdict(32'd0, r);
          end else begin
            parse_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        idx = byte_index;
        if (chunk_type == CK_IDAT) begin
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = b;
          got            = 1'b1;
        end else if (chunk_type == CK_IHDR) begin
          if (idx < 32'd4) begin
            width_seen = {width_seen[23:0], b};
          end else if (idx < 32'd8) begin
            height_seen = {height_seen[23:0], b};
          end else if (idx == 32'd8) begin
            if (b != HDR_DEPTH) return raise_error(ERR_DEPTH, r);
          end else if (idx == 32'd9) begin
            if (b != HDR_COLOR_RGBA) return raise_error(ERR_COLOR_TYPE, r);
          end else if (idx == 32'd10) begin
            if (b != 8'd0) return raise_error(ERR_COMPRESSION, r);
          end else if (idx == 32'd11) begin
            if (b != 8'd0) return raise_error(ERR_FILTER, r);
          end else if (idx == 32'd12) begin
            if (b != 8'd0) return raise_error(ERR_INTERLACE, r);
            r.kind         = KIND_HEADER;
            r.image_width  = width_seen;
            r.image_height = height_seen;
            got            = 1'b1;
          end
        end
        byte_index++;
        if (byte_index == chunk_len) begin
          parse_phase = PH_CRC;
          byte_index  = '0;
          if (chunk_type == CK_IHDR && idx < 32'd12) got = header_verdict(idx + 32'd1, r);
        end
      end
      PH_CRC: begin
        byte_index++;
        if (byte_index >= 32'd4) begin
          parse_phase = PH_LEN;
          byte_index  = '0;
          shift_word  = '0;
        end
      end
      default: begin
      end
    endcase
    return got;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, seen, want);
    mismatch_count++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start, input bit counted);
    stream_byte_t item;
    item.file_start = start;
    item.data_byte  = b;
    byte_queue.push_back(item);
    if (counted) counted_bytes++;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8], 1'b0, 1'b1);
  endtask

  task automatic push_noise(input int unsigned n, input bit counted);
    repeat (n) push_byte(8'($urandom), 1'b0, counted);
  endtask

  task automatic push_signature(input int bad_at);
    logic [7:0] b;
    for (int i = 0; i < 8; i++) begin
      b = SIGNATURE[i];
      if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      push_byte(b, i == 0, 1'b1);
      if (i == bad_at) return;
    end
  endtask

  task automatic push_header(input logic [31:0] len, input logic [31:0] w,
                             input logic [31:0] h, input int bad_field);
    logic [7:0] field [13];
    field = '{w[31:24], w[23:16], w[15:8], w[7:0], h[31:24], h[23:16], h[15:8], h[7:0],
              HDR_DEPTH, HDR_COLOR_RGBA, 8'd0, 8'd0, 8'd0};
    if (bad_field >= 8) field[bad_field] = field[bad_field] ^ 8'($urandom_range(1, 255));
    push_word(len);
    push_word(TAG_IHDR);
    for (int unsigned i = 0; i < len; i++) push_byte(i < 13 ? field[i] : 8'($urandom), 1'b0, 1'b1);
    push_noise(4, 1'b1);
  endtask

  task automatic push_chunk(input logic [31:0] tag, input logic [31:0] len);
    push_word(len);
    push_word(tag);
    push_noise(len, 1'b1);
    push_noise(4, 1'b1);
  endtask

  function automatic logic [31:0] unknown_tag();
    logic [31:0] tag;
    do begin
      for (int i = 0; i < 4; i++) begin
        tag[8*i +: 8] = 8'($urandom_range(0, 1) ? $urandom_range(65, 90) : $urandom_range(97, 122));
      end
    end while (tag == TAG_IHDR || tag == TAG_PLTE || tag == TAG_IDAT || tag == TAG_IEND);
    return tag;
  endfunction

  function automatic logic [31:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(1, 4096));
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic push_random_file();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      push_signature($urandom_range(0, 7));
      push_noise($urandom_range(0, 3), 1'b0);
      return;
    end
    push_signature(8);
    if (pick < 16) begin
      len = $urandom_range(0, 20);
      push_header(len, random_dim(), random_dim(), NO_BAD_FIELD);
      if (len < 10) begin
        push_noise($urandom_range(0, 3), 1'b0);
        return;
      end
    end else if (pick < 28) begin
      push_header(13, random_dim(), random_dim(), $urandom_range(8, 12));
      push_noise($urandom_range(0, 3), 1'b0);
      return;
    end else begin
      push_header(13, random_dim(), random_dim(), NO_BAD_FIELD);
    end
    repeat ($urandom_range(0, 5)) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_chunk(TAG_IDAT, $urandom_range(0, 16));
      end else if (pick < 85) begin
        push_chunk(unknown_tag(), $urandom_range(0, 12));
      end else if (pick < 91) begin
        push_header(13, random_dim(), random_dim(), NO_BAD_FIELD);
      end else if (pick < 95) begin
        push_word($urandom_range(0, 12));
        push_word(TAG_PLTE);
        push_noise($urandom_range(0, 4), 1'b0);
        return;
      end else begin
        // Truncated chunk with a huge length; the next file restarts the parser.
        push_word({8'($urandom_range(1, 255)), 24'($urandom)});
        push_word($urandom_range(0, 1) ? TAG_IDAT : unknown_tag());
        push_noise($urandom_range(0, 10), 1'b1);
        return;
      end
    end
    push_word($urandom_range(0, 4));
    push_word(TAG_IEND);
    push_noise($urandom_range(0, 4), 1'b0);
  endtask

  task automatic build_stimulus();
    push_signature(8);
    push_header(13, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NO_BAD_FIELD);
    push_chunk(TAG_IDAT, 0);
    push_word(32'd3);
    push_word(TAG_IDAT);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h5A, 1'b0, 1'b1);
    push_noise(4, 1'b1);
    push_chunk(unknown_tag(), 2);
    push_header(16, 32'h0, 32'h0, NO_BAD_FIELD);
    push_word(32'd0);
    push_word(TAG_IEND);
    push_noise(3, 1'b0);
    push_signature(0);
    push_signature(7);
    for (int f = 8; f <= 12; f++) begin
      push_signature(8);
      push_header(13, random_dim(), random_dim(), f);
    end
    push_signature(8);
    push_header(0, 32'd1, 32'd1, NO_BAD_FIELD);
    push_signature(8);
    push_header(9, 32'd2, 32'd3, NO_BAD_FIELD);
    push_signature(8);
    push_header(10, 32'h0102_0304, 32'h0506_0708, NO_BAD_FIELD);
    push_word(32'd0);
    push_word(TAG_IEND);
    push_signature(8);
    push_header(13, 32'd16, 32'd16, NO_BAD_FIELD);
    push_word(32'd3);
    push_word(TAG_PLTE);
    push_noise(2, 1'b0);
    push_signature(8);
    push_header(13, 32'd4, 32'd4, NO_BAD_FIELD);
    push_word(32'd5);
    push_word(TAG_IDAT);
    push_noise(2, 1'b1);
    while (counted_bytes < STIMULUS_BYTES) push_random_file();
    total_bytes = byte_queue.size();
  endtask

  function automatic bit idling_on();
    return accepted_bytes < total_bytes - total_bytes / 10 && (accepted_bytes / 150) % 4 != 3;
  endfunction

  always @(posedge clk) begin
    stream_byte_t item;
    if (rst) begin
      stream_ch.valid <= 1'b0;
      gap_left        <= 0;
    end else if (!stream_ch.valid || stream_ch.ready) begin
      if (gap_left != 0) begin
        stream_ch.valid <= 1'b0;
        gap_left        <= gap_left - 1;
      end else if (byte_queue.size() != 0 && idling_on() && $urandom_range(0, 5) == 0) begin
        stream_ch.valid <= 1'b0;
        gap_left        <= $urandom_range(0, 6);
      end else if (byte_queue.size() != 0) begin
        item                 = byte_queue.pop_front();
        stream_ch.valid      <= 1'b1;
        stream_ch.data_byte  <= item.data_byte;
        stream_ch.file_start <= item.file_start;
      end else begin
        stream_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      <= 0;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (idling_on() && $urandom_range(0, 4) == 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= $urandom_range(0, 6);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    parse_result_t seen;
    parse_result_t want;
    parse_result_t next_want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        seen.kind         = kind_t'(result_ch.kind);
        seen.payload_byte = result_ch.payload_byte;
        seen.image_width  = result_ch.image_width;
        seen.image_height = result_ch.image_height;
        seen.error_code   = result_ch.error_code;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, kind", 32'(seen.kind), 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (seen.kind !== want.kind) report_mismatch("kind", 32'(seen.kind), 32'(want.kind));
          if (seen.payload_byte !== want.payload_byte) begin
            report_mismatch("payload_byte", 32'(seen.payload_byte), 32'(want.payload_byte));
          end
          if (seen.image_width !== want.image_width) begin
            report_mismatch("image_width", seen.image_width, want.image_width);
          end
          if (seen.image_height !== want.image_height) begin
            report_mismatch("image_height", seen.image_height, want.image_height);
          end
          if (seen.error_code !== want.error_code) begin
            report_mismatch("error_code", 32'(seen.error_code), 32'(want.error_code));
          end
        end
      end
      if (stream_ch.valid && stream_ch.ready) begin
        if (parse_byte(stream_ch.data_byte, stream_ch.file_start, next_want)) begin
          expected_results.push_back(next_want);
        end
        accepted_bytes <= accepted_bytes + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst                  = 1'b1;
    stream_ch.valid      = 1'b0;
    stream_ch.data_byte  = 8'h00;
    stream_ch.file_start = 1'b0;
    result_ch.ready      = 1'b0;
    counted_bytes        = 0;
    accepted_bytes       = 0;
    mismatch_count       = 0;
    cycle_count          = 0;
    gap_left             = 0;
    stall_left           = 0;
    total_bytes          = 0;
    reset_parser();
    build_stimulus();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (accepted_bytes < total_bytes || expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
